// File: rtl/multizone_range_line_fit_assert.svh
// Assertion macros shared by the checker of the range line fit block
`ifndef MULTIZONE_RANGE_LINE_FIT_ASSERT_SVH
`define MULTIZONE_RANGE_LINE_FIT_ASSERT_SVH

// Clocked property, quiet while reset is asserted
`define MRLF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: property failed");

// Clocked property that is also checked across reset
`define MRLF_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("%m: property failed across reset");

`endif

// File: rtl/mrlf_pkg.sv
// Package: constants, tables and widths of the range line fit block
`timescale 1ns / 1ps
package mrlf_pkg;

    localparam int ZONES_DEF    = 7;
    localparam int WINDOW_DEF   = 4;
    localparam int RANGE_W      = 16;
    localparam int ANGLE_W      = 16;
    localparam int WALL_W       = 20;
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W       = 5;

    typedef logic signed [WALL_W-1:0] t_wall;
    typedef logic signed [17:0]       t_trig;

    localparam logic signed [22:0] HALF_PI_Q20  = 23'sd1647099;
    localparam logic signed [32:0] INV_GAIN_Q30 = 33'sd652032874;
    localparam t_wall              WALL_MAX     = 20'sh7ffff;
    localparam t_wall              WALL_MIN     = 20'sh80000;

    // Arctangent of 2^-i in Q20 radians
    function automatic logic [19:0] atan_step(input logic [STEP_W-1:0] i);
        logic [19:0] v;
        case (i)
            5'd0:  v = 20'd823550;
            5'd1:  v = 20'd486170;
            5'd2:  v = 20'd256879;
            5'd3:  v = 20'd130396;
            5'd4:  v = 20'd65451;
            5'd5:  v = 20'd32757;
            5'd6:  v = 20'd16383;
            5'd7:  v = 20'd8192;
            5'd8:  v = 20'd4096;
            5'd9:  v = 20'd2048;
            5'd10: v = 20'd1024;
            5'd11: v = 20'd512;
            5'd12: v = 20'd256;
            5'd13: v = 20'd128;
            5'd14: v = 20'd64;
            5'd15: v = 20'd32;
            5'd16: v = 20'd16;
            5'd17: v = 20'd8;
            5'd18: v = 20'd4;
            5'd19: v = 20'd2;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

    // Cosine of the zone angle in Q16
    function automatic t_trig zone_cos(input logic [3:0] r);
        t_trig v;
        case (r)
            4'd0:  v = -18'sd15299;
            4'd1:  v = -18'sd10252;
            4'd2:  v = -18'sd5142;
            4'd3:  v = 18'sd0;
            4'd4:  v = 18'sd5142;
            4'd5:  v = 18'sd10252;
            4'd6:  v = 18'sd15299;
            4'd7:  v = 18'sd20252;
            4'd8:  v = 18'sd25080;
            4'd9:  v = 18'sd29753;
            4'd10: v = 18'sd34242;
            4'd11: v = 18'sd38521;
            4'd12: v = 18'sd42562;
            4'd13: v = 18'sd46341;
            4'd14: v = 18'sd49834;
            4'd15: v = 18'sd53020;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

    // Sine of the zone angle in Q16
    function automatic t_trig zone_sin(input logic [3:0] r);
        t_trig v;
        case (r)
            4'd0:  v = 18'sd63725;
            4'd1:  v = 18'sd64729;
            4'd2:  v = 18'sd65334;
            4'd3:  v = 18'sd65536;
            4'd4:  v = 18'sd65334;
            4'd5:  v = 18'sd64729;
            4'd6:  v = 18'sd63725;
            4'd7:  v = 18'sd62328;
            4'd8:  v = 18'sd60547;
            4'd9:  v = 18'sd58393;
            4'd10: v = 18'sd55879;
            4'd11: v = 18'sd53020;
            4'd12: v = 18'sd49834;
            4'd13: v = 18'sd46341;
            4'd14: v = 18'sd42562;
            4'd15: v = 18'sd38521;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/multizone_range_line_fit.sv
// Top level: zone history, running sums and the iterative line fit engine
`timescale 1ns / 1ps
// Takes one range reading per item for zones 0..ZONES-1 in turn and keeps the
// last WINDOW rounds in a history RAM with a running sum per zone. The reading
// that closes a round yields one result: the mean slope angle of the wall line
// through the zone points and the wall distance. After reset the history RAM
// is cleared, one entry a cycle, over all ZONES*WINDOW entries while o_in_stall
// is high. A reading that does not close a round updates its zone in S_UPD and
// the block returns to idle. A closing reading runs the fit on one shared
// shift-add multiplier, one restoring divider and one CORDIC step unit (20
// steps per angle): two products per zone, a normalized pair angle for each
// zone but the first unless the pair is vertical or empty, then the final
// angle, the rotation and the wall division. The x_offset register is taken at
// any time with o_cfg_ready held high; write it only while the block is idle.
module multizone_range_line_fit #(
    parameter int ZONES  = mrlf_pkg::ZONES_DEF,
    parameter int WINDOW = mrlf_pkg::WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic signed [mrlf_pkg::RANGE_W-1:0] i_cfg_x_offset,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [mrlf_pkg::RANGE_W-1:0]        i_range_mm,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [mrlf_pkg::ANGLE_W-1:0] o_line_angle,
    output logic signed [mrlf_pkg::WALL_W-1:0]  o_wall_distance,
    output logic                                o_saturated
);
    import mrlf_pkg::*;

    localparam int ZB    = $clog2(ZONES);
    localparam int DEPTH = ZONES * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUMW  = RANGE_W + $clog2(WINDOW);
    localparam int DW    = 48;
    localparam int MBW   = 18;

    localparam logic [AW-1:0]      LAST_BASE = AW'((WINDOW - 1) * ZONES);
    localparam logic [AW-1:0]      BASE_STEP = AW'(ZONES);
    localparam logic [AW-1:0]      CLR_LAST  = AW'(DEPTH - 1);
    localparam logic [ZB-1:0]      ZONE_LAST = ZB'(ZONES - 1);
    localparam logic signed [18:0] ZW_MUL    = 19'(DEPTH);
    localparam logic [63:0]        D_CONST   = 64'(DEPTH) << 16;
    localparam logic [63:0]        ANG_DIV   = 64'(ZONES - 1);
    localparam logic [63:0]        ANG_HALF  = 64'((ZONES - 1) / 2);
    localparam logic signed [DW-1:0] NORM_LIM = 48'sh010000000000;
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    // Sequencer states
    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_UPD  = 5'd2;
    localparam logic [4:0] S_XR   = 5'd3;
    localparam logic [4:0] S_YR   = 5'd4;
    localparam logic [4:0] S_PAIR = 5'd5;
    localparam logic [4:0] S_NORM = 5'd6;
    localparam logic [4:0] S_VEC  = 5'd7;
    localparam logic [4:0] S_NEXT = 5'd8;
    localparam logic [4:0] S_ADIV = 5'd9;
    localparam logic [4:0] S_ROT0 = 5'd10;
    localparam logic [4:0] S_ROT  = 5'd11;
    localparam logic [4:0] S_OFF  = 5'd12;
    localparam logic [4:0] S_XA   = 5'd13;
    localparam logic [4:0] S_M2   = 5'd14;
    localparam logic [4:0] S_M3   = 5'd15;
    localparam logic [4:0] S_M4   = 5'd16;
    localparam logic [4:0] S_WDIV = 5'd17;
    localparam logic [4:0] S_WQ   = 5'd18;
    localparam logic [4:0] S_FIN  = 5'd19;
    localparam logic [4:0] S_MUL  = 5'd20;
    localparam logic [4:0] S_DIV  = 5'd21;

    // Control registers
    logic [4:0]        r_state, n_state, r_ret, n_ret;
    logic [ZB-1:0]     r_zone, n_zone;
    logic [AW-1:0]     r_base, n_base, r_clr, n_clr;
    logic [SUMW-1:0]   r_sum [ZONES];
    logic [SUMW-1:0]   n_sum [ZONES];
    logic signed [RANGE_W-1:0] r_xoff, n_xoff;
    logic              r_ovalid, n_ovalid;

    // Datapath registers
    logic [RANGE_W-1:0]      r_reading, n_reading;
    logic signed [DW-1:0]    r_sx, n_sx, r_sy, n_sy, r_xr, n_xr, r_yr, n_yr;
    logic signed [DW-1:0]    r_px, n_px, r_py, n_py, r_cx, n_cx, r_cy, n_cy;
    logic signed [DW-1:0]    r_xa, n_xa;
    logic signed [22:0]      r_cz, n_cz;
    logic [STEP_W-1:0]       r_step, n_step;
    logic signed [26:0]      r_asum, n_asum;
    logic signed [21:0]      r_ang, n_ang;
    logic signed [ANGLE_W-1:0] r_line, n_line;
    logic signed [32:0]      r_rx, n_rx, r_ry, n_ry;
    logic signed [23:0]      r_rz, n_rz;
    logic signed [18:0]      r_c, n_c, r_s, n_s;
    logic signed [63:0]      r_num, n_num;
    logic [63:0]             r_den, n_den;
    t_wall                   r_wall, n_wall;
    logic                    r_sat, n_sat;

    // Shift-add multiplier
    logic [63:0]             r_ma, n_ma, r_macc, n_macc;
    logic [MBW-1:0]          r_mb, n_mb;
    logic                    r_msgn, n_msgn;
    logic [4:0]              r_mcnt, n_mcnt;

    // Restoring divider
    logic [63:0]             r_dn, n_dn, r_dd, n_dd, r_rem, n_rem, r_q, n_q;
    logic [5:0]              r_dcnt, n_dcnt;

    // Output register
    logic signed [ANGLE_W-1:0] r_oline, n_oline;
    t_wall                     r_owall, n_owall;
    logic                      r_osat, n_osat;

    // RAM port
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_addr;
    logic [RANGE_W-1:0] ram_wdata, ram_rdata;

    // Launch requests for the shared units
    logic               mul_go, div_go;
    logic signed [63:0] mul_a;
    logic signed [18:0] mul_b, mul_b_abs;
    logic [4:0]         mul_ret, div_ret;
    logic [63:0]        div_n, div_d;

    // Shared helpers
    logic               in_accept;
    logic [SUMW-1:0]    sum_rd;
    logic signed [63:0] prod, asum64, sy64;
    logic signed [DW-1:0] dx, dy, dx_n, dy_n, yr_w, xa_w;
    logic signed [DW-1:0] vx_sh, vy_sh, vnx, vny;
    logic signed [22:0]   vnz, atan_v;
    logic signed [32:0]   rx_sh, ry_sh, rnx, rny, c_full, s_full;
    logic signed [23:0]   rnz;
    logic [21:0]          qa, lm;
    logic signed [21:0]   ang_v;
    logic [64:0]          rem_sh;
    logic [63:0]          num_abs;

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign ram_addr    = r_base + AW'(r_zone);
    assign sum_rd      = r_sum[r_zone];
    assign prod        = r_msgn ? -$signed(r_macc) : $signed(r_macc);
    assign asum64      = 64'(r_asum);
    assign sy64        = 64'(r_sy);
    assign atan_v      = $signed({3'b000, atan_step(r_step)});

    // Pair angle CORDIC step: vectoring toward the x axis
    assign vx_sh = r_cx >>> r_step;
    assign vy_sh = r_cy >>> r_step;
    assign vnx   = (r_cy > 48'sd0) ? r_cx + vy_sh : r_cx - vy_sh;
    assign vny   = (r_cy > 48'sd0) ? r_cy - vx_sh : r_cy + vx_sh;
    assign vnz   = (r_cy > 48'sd0) ? r_cz + atan_v : r_cz - atan_v;

    // Rotation CORDIC step: turn 1/K by the mean angle
    assign rx_sh  = r_rx >>> r_step;
    assign ry_sh  = r_ry >>> r_step;
    assign rnx    = (r_rz >= 24'sd0) ? r_rx - ry_sh : r_rx + ry_sh;
    assign rny    = (r_rz >= 24'sd0) ? r_ry + rx_sh : r_ry - rx_sh;
    assign rnz    = (r_rz >= 24'sd0) ? r_rz - 24'(atan_v) : r_rz + 24'(atan_v);
    assign c_full = (rnx + 33'sd8192) >>> 14;
    assign s_full = (rny + 33'sd8192) >>> 14;

    // Neighbor differences, folded into the right half plane
    assign yr_w = prod[DW-1:0];
    assign dx   = r_xr - r_px;
    assign dy   = yr_w - r_py;
    assign dx_n = (dx < 48'sd0) ? -dx : dx;
    assign dy_n = (dx < 48'sd0) ? -dy : dy;

    // Mean angle and its Q2.14 form, rounded half away from zero
    assign qa    = r_q[21:0];
    assign ang_v = r_asum[26] ? -$signed(qa) : $signed(qa);
    assign lm    = (qa + 22'd32) >> 6;

    assign xa_w    = r_sx + $signed({prod[31:0], 16'h0000});
    assign rem_sh  = {r_rem, r_dn[63]};
    assign num_abs = r_num[63] ? 64'(-r_num) : 64'(r_num);
    assign mul_b_abs = mul_b[18] ? -mul_b : mul_b;

    // Sequencer and shared units
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_zone    = r_zone;
        n_base    = r_base;
        n_clr     = r_clr;
        n_sum     = r_sum;
        n_xoff    = r_xoff;
        n_ovalid  = r_ovalid && i_out_stall;
        n_reading = r_reading;
        n_sx = r_sx; n_sy = r_sy; n_xr = r_xr; n_yr = r_yr;
        n_px = r_px; n_py = r_py; n_cx = r_cx; n_cy = r_cy;
        n_xa = r_xa; n_cz = r_cz; n_step = r_step; n_asum = r_asum;
        n_ang = r_ang; n_line = r_line;
        n_rx = r_rx; n_ry = r_ry; n_rz = r_rz; n_c = r_c; n_s = r_s;
        n_num = r_num; n_den = r_den; n_wall = r_wall; n_sat = r_sat;
        n_ma = r_ma; n_mb = r_mb; n_macc = r_macc; n_msgn = r_msgn;
        n_mcnt = r_mcnt;
        n_dn = r_dn; n_dd = r_dd; n_rem = r_rem; n_q = r_q; n_dcnt = r_dcnt;
        n_oline = r_oline; n_owall = r_owall; n_osat = r_osat;
        ram_we    = 1'b0;
        ram_waddr = ram_addr;
        ram_wdata = r_reading;
        ram_re    = in_accept;
        mul_go  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        mul_ret = S_IDLE;
        div_go  = 1'b0;
        div_n   = '0;
        div_d   = '0;
        div_ret = S_IDLE;

        if (i_cfg_valid) begin
            n_xoff = i_cfg_x_offset;
        end

        case (r_state)
            // Zero the history RAM after reset
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_reading = i_range_mm;
                    n_state   = S_UPD;
                end
            end
            // Swap the oldest reading of this zone for the new one
            S_UPD: begin
                ram_we = 1'b1;
                n_sum[r_zone] = sum_rd - SUMW'(ram_rdata) + SUMW'(r_reading);
                if (r_zone == ZONE_LAST) begin
                    n_zone  = '0;
                    n_base  = (r_base == LAST_BASE) ? '0 : r_base + BASE_STEP;
                    n_sx    = '0;
                    n_sy    = '0;
                    n_asum  = '0;
                    n_state = S_XR;
                end else begin
                    n_zone  = r_zone + 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_XR: begin
                mul_go  = 1'b1;
                mul_a   = $signed(64'(sum_rd));
                mul_b   = 19'(zone_cos(4'(r_zone)));
                mul_ret = S_YR;
            end
            S_YR: begin
                n_xr    = prod[DW-1:0];
                mul_go  = 1'b1;
                mul_a   = $signed(64'(sum_rd));
                mul_b   = 19'(zone_sin(4'(r_zone)));
                mul_ret = S_PAIR;
            end
            // Accumulate the point; past the first zone, add +-pi/2 for a vertical pair or start the pair angle
            S_PAIR: begin
                n_yr = yr_w;
                n_sx = r_sx + r_xr;
                n_sy = r_sy + yr_w;
                if (r_zone == '0) begin
                    n_state = S_NEXT;
                end else if (dx_n == 48'sd0) begin
                    if (dy_n > 48'sd0) begin
                        n_asum = r_asum + 27'(HALF_PI_Q20);
                    end else if (dy_n < 48'sd0) begin
                        n_asum = r_asum - 27'(HALF_PI_Q20);
                    end
                    n_state = S_NEXT;
                end else begin
                    n_cx    = dx_n;
                    n_cy    = dy_n;
                    n_cz    = '0;
                    n_step  = '0;
                    n_state = S_NORM;
                end
            end
            // Double the vector one bit a cycle up to the working range
            S_NORM: begin
                if (r_cx < NORM_LIM && r_cy < NORM_LIM && r_cy > -NORM_LIM) begin
                    n_cx = r_cx <<< 1;
                    n_cy = r_cy <<< 1;
                end else begin
                    n_state = S_VEC;
                end
            end
            S_VEC: begin
                n_cx = vnx;
                n_cy = vny;
                n_cz = vnz;
                if (r_step == STEP_LAST) begin
                    n_asum  = r_asum + 27'(vnz);
                    n_state = S_NEXT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_NEXT: begin
                n_px = r_xr;
                n_py = r_yr;
                if (r_zone == ZONE_LAST) begin
                    n_zone  = '0;
                    n_state = S_ADIV;
                end else begin
                    n_zone  = r_zone + 1'b1;
                    n_state = S_XR;
                end
            end
            // Mean of the pair angles
            S_ADIV: begin
                div_go  = 1'b1;
                div_n   = (r_asum[26] ? 64'(-asum64) : 64'(asum64)) + ANG_HALF;
                div_d   = ANG_DIV;
                div_ret = S_ROT0;
            end
            S_ROT0: begin
                n_ang   = ang_v;
                n_line  = r_asum[26] ? -$signed(lm[ANGLE_W-1:0])
                                     : $signed(lm[ANGLE_W-1:0]);
                n_rx    = INV_GAIN_Q30;
                n_ry    = '0;
                n_rz    = 24'(ang_v);
                n_step  = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                n_rx = rnx;
                n_ry = rny;
                n_rz = rnz;
                if (r_step == STEP_LAST) begin
                    n_c     = c_full[18:0];
                    n_s     = s_full[18:0];
                    n_state = S_OFF;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_OFF: begin
                mul_go  = 1'b1;
                mul_a   = 64'(r_xoff);
                mul_b   = ZW_MUL;
                mul_ret = S_XA;
            end
            // Pick the wall path: regular, vertical through origin, or clipped
            S_XA: begin
                n_xa = xa_w;
                if (r_c > 19'sd0) begin
                    mul_go  = 1'b1;
                    mul_a   = sy64;
                    mul_b   = r_c;
                    mul_ret = S_M2;
                end else if (xa_w == 48'sd0) begin
                    n_num   = sy64;
                    n_den   = D_CONST;
                    n_state = S_WDIV;
                end else begin
                    n_sat   = 1'b1;
                    n_wall  = ((xa_w > 48'sd0) == (r_ang > 22'sd0)) ? WALL_MIN : WALL_MAX;
                    n_state = S_FIN;
                end
            end
            S_M2: begin
                n_num   = prod;
                mul_go  = 1'b1;
                mul_a   = 64'(r_xa);
                mul_b   = r_s;
                mul_ret = S_M3;
            end
            S_M3: begin
                n_num   = r_num - prod;
                mul_go  = 1'b1;
                mul_a   = 64'(r_c);
                mul_b   = ZW_MUL;
                mul_ret = S_M4;
            end
            S_M4: begin
                n_den   = {prod[47:0], 16'h0000};
                n_state = S_WDIV;
            end
            S_WDIV: begin
                div_go  = 1'b1;
                div_n   = num_abs + (r_den >> 1);
                div_d   = r_den;
                div_ret = S_WQ;
            end
            // Apply the sign and clip to the wall range
            S_WQ: begin
                n_sat = 1'b0;
                if (!r_num[63]) begin
                    if (r_q > 64'd524287) begin
                        n_wall = WALL_MAX;
                        n_sat  = 1'b1;
                    end else begin
                        n_wall = $signed(r_q[WALL_W-1:0]);
                    end
                end else begin
                    if (r_q > 64'd524288) begin
                        n_wall = WALL_MIN;
                        n_sat  = 1'b1;
                    end else begin
                        n_wall = -$signed(r_q[WALL_W-1:0]);
                    end
                end
                n_state = S_FIN;
            end
            // Hand the item to the output register once it is free
            S_FIN: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_oline  = r_line;
                    n_owall  = r_wall;
                    n_osat   = r_sat;
                    n_state  = S_IDLE;
                end
            end
            S_MUL: begin
                if (r_mb[0]) begin
                    n_macc = r_macc + r_ma;
                end
                n_ma   = r_ma << 1;
                n_mb   = r_mb >> 1;
                n_mcnt = r_mcnt + 1'b1;
                if (r_mcnt == 5'(MBW - 1)) begin
                    n_state = r_ret;
                end
            end
            S_DIV: begin
                if (rem_sh >= {1'b0, r_dd}) begin
                    n_rem = 64'(rem_sh - {1'b0, r_dd});
                    n_q   = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = rem_sh[63:0];
                    n_q   = {r_q[62:0], 1'b0};
                end
                n_dn   = r_dn << 1;
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == 6'd63) begin
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Start the multiplier on magnitudes
        if (mul_go) begin
            n_ma    = mul_a[63] ? 64'(-mul_a) : 64'(mul_a);
            n_mb    = mul_b_abs[MBW-1:0];
            n_msgn  = mul_a[63] ^ mul_b[18];
            n_macc  = '0;
            n_mcnt  = '0;
            n_ret   = mul_ret;
            n_state = S_MUL;
        end

        // Start the divider
        if (div_go) begin
            n_dn    = div_n;
            n_dd    = div_d;
            n_rem   = '0;
            n_q     = '0;
            n_dcnt  = '0;
            n_ret   = div_ret;
            n_state = S_DIV;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ret    <= S_IDLE;
            r_zone   <= '0;
            r_base   <= '0;
            r_clr    <= '0;
            r_sum    <= '{default: '0};
            r_xoff   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_zone   <= n_zone;
            r_base   <= n_base;
            r_clr    <= n_clr;
            r_sum    <= n_sum;
            r_xoff   <= n_xoff;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath, no reset
    always_ff @(posedge i_clk) begin
        r_reading <= n_reading;
        r_sx <= n_sx; r_sy <= n_sy; r_xr <= n_xr; r_yr <= n_yr;
        r_px <= n_px; r_py <= n_py; r_cx <= n_cx; r_cy <= n_cy;
        r_xa <= n_xa; r_cz <= n_cz; r_step <= n_step; r_asum <= n_asum;
        r_ang <= n_ang; r_line <= n_line;
        r_rx <= n_rx; r_ry <= n_ry; r_rz <= n_rz; r_c <= n_c; r_s <= n_s;
        r_num <= n_num; r_den <= n_den; r_wall <= n_wall; r_sat <= n_sat;
        r_ma <= n_ma; r_mb <= n_mb; r_macc <= n_macc; r_msgn <= n_msgn;
        r_mcnt <= n_mcnt;
        r_dn <= n_dn; r_dd <= n_dd; r_rem <= n_rem; r_q <= n_q; r_dcnt <= n_dcnt;
        r_oline <= n_oline; r_owall <= n_owall; r_osat <= n_osat;
    end

    // History of the last WINDOW rounds
    mrlf_ram #(
        .WIDTH (RANGE_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid     = r_ovalid;
    assign o_line_angle    = r_oline;
    assign o_wall_distance = r_owall;
    assign o_saturated     = r_osat;

endmodule

// File: rtl/mrlf_ram.sv
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
module mrlf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mrlf_checker.sv
// Port level checker for the range line fit block, bound to the top level
`timescale 1ns / 1ps
module mrlf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready,
    input logic signed [mrlf_pkg::RANGE_W-1:0] i_cfg_x_offset,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic [mrlf_pkg::RANGE_W-1:0]        i_range_mm,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [mrlf_pkg::ANGLE_W-1:0] o_line_angle,
    input logic signed [mrlf_pkg::WALL_W-1:0]  o_wall_distance,
    input logic                                o_saturated
);
    import mrlf_pkg::*;
`include "multizone_range_line_fit_assert.svh"

    logic wall_at_end;

    // Wall sits at either end of its range
    assign wall_at_end = (o_wall_distance == WALL_MAX) || (o_wall_distance == WALL_MIN);

    // Reset drops any result and holds off input during the RAM clear
    `MRLF_ASSERT_RST(a_reset_quiet, !i_rst_n |=> (!o_out_valid && o_in_stall))

    // One item at a time: an accepted item makes the block busy
    `MRLF_ASSERT(a_busy_after_item, (i_in_valid && !o_in_stall) |=> o_in_stall)

    // A stalled result stays offered
    `MRLF_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> o_out_valid)

    // A clipped wall sits at one end of its range
    `MRLF_ASSERT(a_sat_at_limit, (o_out_valid && o_saturated) |-> wall_at_end)

endmodule

bind multizone_range_line_fit mrlf_checker u_mrlf_checker (.*);

// File: bench/multizone_range_line_fit_check.sv
// Checker: predicts wall line fit results from accepted items and compares them
`timescale 1ns / 1ps
module multizone_range_line_fit_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic signed [15:0] i_cfg_x_offset,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [15:0] i_range_mm,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic signed [15:0] i_line_angle,
    input  logic signed [19:0] i_wall_distance,
    input  logic        i_saturated,
    output int          o_errors,
    output int          o_pending
);
    localparam int ZN = mrlf_pkg::ZONES_DEF;
    localparam int WN = mrlf_pkg::WINDOW_DEF;
    localparam longint VERT_Q20 = 1647099;
    localparam longint INV_K_Q30 = 652032874;
    localparam longint WALL_HI = 524287;
    localparam longint WALL_LO = -524288;
    localparam longint NORM_CAP = 64'sd1 << 40;

    typedef struct packed {
        logic signed [15:0] angle;
        logic signed [19:0] wall;
        logic               sat;
    } fit_t;

    localparam longint COS_Q16 [7] = '{-15299, -10252, -5142, 0, 5142, 10252, 15299};
    localparam longint SIN_Q16 [7] = '{63725, 64729, 65334, 65536, 65334, 64729, 63725};
    localparam longint ATAN_Q20 [20] = '{823550, 486170, 256879, 130396, 65451, 32757,
        16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

    logic [15:0]        round_buf [ZN];
    logic [15:0]        ring [WN][ZN];
    longint             zone_total [ZN];
    int                 zone_pos;
    int                 ring_pos;
    logic signed [15:0] lateral_offset;
    fit_t               fits_due [$];

    // Divide rounding half away from zero, divisor positive
    function automatic longint round_div(longint n, longint d);
        return n >= 0 ? (n + d / 2) / d : -((-n + d / 2) / d);
    endfunction

    // Slope angle of one segment by CORDIC vectoring, Q20
    function automatic longint slope_angle(longint dx, longint dy);
        longint x, y, z, nx, ny;
        z = 0;
        if (dx < 0) begin
            dx = -dx;
            dy = -dy;
        end
        if (dx == 0)
            return dy > 0 ? VERT_Q20 : (dy < 0 ? -VERT_Q20 : 0);
        while (dx < NORM_CAP && dy < NORM_CAP && dy > -NORM_CAP) begin
            dx = dx * 2;
            dy = dy * 2;
        end
        x = dx;
        y = dy;
        for (int i = 0; i < 20; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_Q20[i];
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_Q20[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    // Fit the line through the zone means
    function automatic fit_t fit_wall();
        longint sx, sy, px, py, asum, xr, yr, ang, d, xa, x, y, z, nx, ny, c, s, w;
        fit_t f;
        sx = 0; sy = 0; px = 0; py = 0; asum = 0;
        f.sat = 1'b0;
        for (int r = 0; r < ZN; r++) begin
            xr = zone_total[r] * COS_Q16[r];
            yr = zone_total[r] * SIN_Q16[r];
            sx += xr;
            sy += yr;
            if (r > 0) asum += slope_angle(xr - px, yr - py);
            px = xr;
            py = yr;
        end
        ang = round_div(asum, ZN - 1);
        f.angle = 16'(round_div(ang, 64));
        d = longint'(ZN) * WN * 65536;
        xa = sx + longint'(lateral_offset) * d;
        // rotate the unit vector to the mean angle
        x = INV_K_Q30; y = 0; z = ang;
        for (int i = 0; i < 20; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_Q20[i];
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_Q20[i];
            end
            x = nx;
            y = ny;
        end
        c = (x + 8192) >>> 14;
        s = (y + 8192) >>> 14;
        if (c > 0)
            w = round_div(sy * c - xa * s, c * d);
        else if (xa == 0)
            w = round_div(sy, d);
        else
            w = ((xa > 0) == (ang > 0)) ? WALL_LO - 1 : WALL_HI + 1;
        if (w > WALL_HI) begin
            w = WALL_HI; f.sat = 1'b1;
        end
        if (w < WALL_LO) begin
            w = WALL_LO; f.sat = 1'b1;
        end
        f.wall = 20'(w);
        return f;
    endfunction

    assign o_pending = fits_due.size();

    // Track state, predict on each item, compare each result
    always @(posedge i_clk) begin
        fit_t want;
        if (!i_rst_n) begin
            zone_pos = 0;
            ring_pos = 0;
            lateral_offset = '0;
            o_errors = 0;
            fits_due.delete();
            for (int r = 0; r < ZN; r++) begin
                zone_total[r] = 0;
                round_buf[r] = '0;
                for (int k = 0; k < WN; k++) ring[k][r] = '0;
            end
        end else begin
            if (i_cfg_valid && i_cfg_ready) lateral_offset = i_cfg_x_offset;
            if (i_in_valid && !i_in_stall) begin
                round_buf[zone_pos] = i_range_mm;
                zone_pos++;
                if (zone_pos == ZN) begin
                    zone_pos = 0;
                    for (int r = 0; r < ZN; r++) begin
                        zone_total[r] = zone_total[r] - ring[ring_pos][r] + round_buf[r];
                        ring[ring_pos][r] = round_buf[r];
                    end
                    ring_pos = (ring_pos + 1) % WN;
                    fits_due.push_back(fit_wall());
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (fits_due.size() == 0) begin
                    $display("%0t: unexpected result angle=%0d wall=%0d sat=%0b", $time,
                             i_line_angle, i_wall_distance, i_saturated);
                    o_errors++;
                end else begin
                    want = fits_due.pop_front();
                    if (i_line_angle !== want.angle) begin
                        $display("%0t: line_angle expected %0d actual %0d", $time,
                                 want.angle, i_line_angle);
                        o_errors++;
                    end
                    if (i_wall_distance !== want.wall) begin
                        $display("%0t: wall_distance expected %0d actual %0d", $time,
                                 want.wall, i_wall_distance);
                        o_errors++;
                    end
                    if (i_saturated !== want.sat) begin
                        $display("%0t: saturated expected %0b actual %0b", $time,
                                 want.sat, i_saturated);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

// File: bench/multizone_range_line_fit_test.sv
// Testbench top: drives readings and offsets, stalls results, gives the verdict
`timescale 1ns / 1ps
module multizone_range_line_fit_test;
    localparam int ZN = mrlf_pkg::ZONES_DEF;
    localparam int IDLE_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic signed [15:0] i_cfg_x_offset = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [15:0]        i_range_mm = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [15:0] o_line_angle;
    logic signed [19:0] o_wall_distance;
    logic               o_saturated;
    int                 fail_count;
    int                 fits_open;
    int                 idle_cycles = 0;
    logic               calm = 1'b0;
    int                 sent = 0;

    multizone_range_line_fit dut (.*);

    multizone_range_line_fit_check checker_i (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_x_offset,
        .i_in_valid, .i_in_stall(o_in_stall), .i_range_mm,
        .i_out_valid(o_out_valid), .i_out_stall, .i_line_angle(o_line_angle),
        .i_wall_distance(o_wall_distance), .i_saturated(o_saturated),
        .o_errors(fail_count), .o_pending(fits_open)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Stall the result side for a random count before each result
    initial begin
        int n;
        forever begin
            n = calm ? 0 : $urandom_range(0, 11);
            if (n > 0) begin
                @(negedge i_clk) i_out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Offer one reading after a random gap
    task automatic send_reading(input logic [15:0] v);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_range_mm <= v;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    task automatic send_round(input logic [15:0] v [ZN]);
        for (int r = 0; r < ZN; r++) send_reading(v[r]);
    endtask

    // Hold the sender until all results are out, then let the block settle
    task automatic drain();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (fits_open != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_offset(input logic signed [15:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_x_offset <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Build one round: wall-like ramp, full random, extremes or sparse zeros
    task automatic random_round();
        logic [15:0] v [ZN];
        int kind, base, step, t;
        kind = $urandom_range(0, 9);
        base = $urandom_range(50, 6000);
        step = $urandom_range(0, 800) - 400;
        for (int r = 0; r < ZN; r++) begin
            case (kind)
                0, 1, 2, 3: begin
                    t = base + step * r + $urandom_range(0, 60) - 30;
                    v[r] = t < 0 ? 16'd0 : 16'(t);
                end
                4, 5: v[r] = 16'($urandom);
                6: v[r] = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                7: v[r] = $urandom_range(0, 2) == 0 ? 16'd0 : 16'($urandom_range(1, 9000));
                default: v[r] = 16'($urandom_range(0, 65535));
            endcase
        end
        send_round(v);
    endtask

    initial begin
        logic [15:0] v [ZN];
        logic signed [15:0] offs [4];
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: coincident points, full scale, vertical segment, ramp
        write_offset(16'sd0);
        v = '{default: 16'd0};
        send_round(v);
        v = '{default: 16'hffff};
        send_round(v);
        v = '{16'd1200, 16'd900, 16'd0, 16'hffff, 16'd0, 16'd700, 16'd1};
        send_round(v);
        v = '{16'd3000, 16'd2500, 16'd2000, 16'd1500, 16'd1000, 16'd500, 16'd1};
        send_round(v);
        drain();

        // Random phases across offset extremes, one phase with no idling
        offs = '{16'sh7fff, -16'sh8000, 16'($urandom), 16'($urandom_range(0, 400) - 200)};
        for (int p = 0; p < 4; p++) begin
            write_offset(offs[p]);
            calm = (p == 2);
            repeat (27) random_round();
            drain();
        end
        calm = 1'b0;

        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && fits_open == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
